// ----- hdl/cep_pkg.sv -----
// Shared types, constants and helpers for the streaming Canny edge core.
// No dependencies; every other file of the core but cep_ram uses this package.
package cep_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int MinDim    = 3;

  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int FwW      = 11;
  localparam int FhW      = 13;
  localparam int ThrW     = 11;
  localparam int PixW     = 8;
  localparam int EdgeW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int MagW     = 22;
  localparam int GradW    = MagW + 2;
  localparam int PrimeW   = 12;
  localparam int WinN     = 3;
  localparam int SumW     = PixW + 3;
  localparam int AbsW     = PixW + 2;
  localparam int SqW      = 2 * AbsW;

  typedef enum logic {
    KindPixel = 1'b0,
    KindFlush = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgLowThr      = 2'd2,
    CfgHighThr     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SectHoriz = 2'd0,
    SectDiag  = 2'd1,
    SectVert  = 2'd2,
    SectAnti  = 2'd3
  } sector_e;

  localparam logic [EdgeW-1:0] EdgeStrong = 8'd255;
  localparam logic [EdgeW-1:0] EdgeWeak   = 8'd127;
  localparam logic [EdgeW-1:0] EdgeNone   = 8'd0;

  // Per-word sideband that rides down the pipeline.
  typedef struct packed {
    logic            valid;
    logic            emit;
    logic            qint;
    logic            fend;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } meta_t;

  typedef struct packed {
    logic [MagW-1:0] mag;
    sector_e         sector;
  } grad_t;

  function automatic logic [ColW-1:0] col_step(input logic [ColW-1:0] c,
                                               input logic [FwW-1:0]  w);
    logic [FwW-1:0] c1;
    c1 = FwW'(c) + FwW'(1);
    return (c1 >= w) ? '0 : c1[ColW-1:0];
  endfunction

endpackage

// ----- hdl/cep_pix_if.sv -----
// Input channel of the edge core: valid/ready with kind and pixel payload.
// Depends on cep_pkg.
interface cep_pix_if;
  logic                      valid;
  logic                      ready;
  cep_pkg::kind_e            kind;
  logic [cep_pkg::PixW-1:0]  pixel_value;

  modport source (output valid, kind, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_value, output ready);
endinterface

// ----- hdl/cep_edge_if.sv -----
// Result channel of the edge core: valid/ready with edge class and position.
// Depends on cep_pkg.
interface cep_edge_if;
  logic                      valid;
  logic                      ready;
  logic [cep_pkg::EdgeW-1:0] edge_value;
  logic [cep_pkg::ColW-1:0]  out_col;
  logic [cep_pkg::RowW-1:0]  out_row;
  logic                      frame_end;

  modport source (output valid, edge_value, out_col, out_row, frame_end, input ready);
  modport sink   (input valid, edge_value, out_col, out_row, frame_end, output ready);
endinterface

// ----- hdl/cep_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cep_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/cep_sobel.sv -----
// Pixel line memory, 3x3 pixel window and the Sobel gradient pipeline
// (gradient, squares, magnitude and sector). Depends on cep_pkg and cep_ram.
module cep_sobel (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    push_i,
  input  logic [cep_pkg::PixW-1:0] pix_i,
  input  cep_pkg::meta_t          meta_i,
  input  logic [cep_pkg::FwW-1:0] effw_i,
  output cep_pkg::meta_t          meta_o,
  output cep_pkg::grad_t          grad_o
);
  import cep_pkg::*;

  logic [ColW-1:0]     pcol_q;
  logic [ColW-1:0]     pcol;
  logic [ColW-1:0]     raddr;
  logic [2*PixW-1:0]   rdata;
  logic [PixW-1:0]     pw_q [WinN][WinN];
  meta_t               m1_q, m2_q, m3_q;
  logic signed [SumW-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [SumW-1:0]     lsum, rsum, tsum, bsum;
  logic [SumW-1:0]     axw, ayw;
  logic [AbsW-1:0]     ax, ay, dif;
  logic [AbsW:0]       sum;
  logic [SqW-1:0]      ax2_q, ay2_q, dif2_q;
  logic [MagW-1:0]     sum2_q;
  logic                ayz_q, aygt_q, same_q;
  logic [SqW:0]        twoax2;
  grad_t               g;

  // Restart at column zero when the width shrank below the stored column.
  assign pcol  = (FwW'(pcol_q) >= effw_i) ? '0 : pcol_q;

  // Read the column of the next word in advance, since the RAM read data is registered.
  assign raddr = push_i ? col_step(pcol, effw_i) : pcol;

  // Entry holds {two rows up, one row up}.
  cep_ram #(.Width(2*PixW), .Depth(MaxWidth)) u_line (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (pcol),
    .wdata_i ({rdata[PixW-1:0], pix_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
    end else if (push_i) begin
      pcol_q <= col_step(pcol, effw_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int r = 0; r < WinN; r++) begin
        pw_q[r][0] <= pw_q[r][1];
        pw_q[r][1] <= pw_q[r][2];
      end
      pw_q[0][2] <= rdata[2*PixW-1:PixW];
      pw_q[1][2] <= rdata[PixW-1:0];
      pw_q[2][2] <= pix_i;
    end
  end

  always_comb begin
    lsum = SumW'(pw_q[0][0]) + SumW'({pw_q[1][0], 1'b0}) + SumW'(pw_q[2][0]);
    rsum = SumW'(pw_q[0][2]) + SumW'({pw_q[1][2], 1'b0}) + SumW'(pw_q[2][2]);
    tsum = SumW'(pw_q[0][0]) + SumW'({pw_q[0][1], 1'b0}) + SumW'(pw_q[0][2]);
    bsum = SumW'(pw_q[2][0]) + SumW'({pw_q[2][1], 1'b0}) + SumW'(pw_q[2][2]);
    gx_d = signed'(rsum - lsum);
    gy_d = signed'(bsum - tsum);
  end

  always_comb begin
    axw = gx_q[SumW-1] ? SumW'(-gx_q) : SumW'(gx_q);
    ayw = gy_q[SumW-1] ? SumW'(-gy_q) : SumW'(gy_q);
    ax  = axw[AbsW-1:0];
    ay  = ayw[AbsW-1:0];
    sum = (AbsW+1)'(ax) + (AbsW+1)'(ay);
    dif = (ay > ax) ? ay - ax : ax - ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
    end else if (adv_i) begin
      m1_q <= meta_i;
      m2_q <= m1_q;
      m3_q <= m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      ax2_q  <= SqW'(ax) * SqW'(ax);
      ay2_q  <= SqW'(ay) * SqW'(ay);
      dif2_q <= SqW'(dif) * SqW'(dif);
      sum2_q <= MagW'(sum) * MagW'(sum);
      ayz_q  <= (ay == '0);
      aygt_q <= (ay > ax);
      same_q <= ((gx_q > 0) == (gy_q > 0));
    end
  end

  // Sector limits tan(22.5) and tan(67.5) tested on squares.
  always_comb begin
    twoax2 = {ax2_q, 1'b0};
    g.mag  = MagW'(ax2_q) + MagW'(ay2_q);
    priority if (ayz_q || (sum2_q < MagW'(twoax2))) begin
      g.sector = SectHoriz;
    end else if (aygt_q && ((SqW+1)'(dif2_q) > twoax2)) begin
      g.sector = SectVert;
    end else if (same_q) begin
      g.sector = SectDiag;
    end else begin
      g.sector = SectAnti;
    end
  end

  // Border and not-yet-framed pixels carry a zero gradient.
  assign grad_o = m3_q.qint ? g : '0;
  assign meta_o = m3_q;
endmodule

// ----- hdl/cep_nms.sv -----
// Gradient line memory, 3x3 gradient window, non-maximum suppression and
// double threshold. Depends on cep_pkg and cep_ram.
module cep_nms (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  cep_pkg::meta_t           meta_i,
  input  cep_pkg::grad_t           grad_i,
  input  logic [cep_pkg::FwW-1:0]  effw_i,
  input  logic [cep_pkg::MagW-1:0] lo2_i,
  input  logic [cep_pkg::MagW-1:0] hi2_i,
  output cep_pkg::meta_t           meta_o,
  output logic [cep_pkg::EdgeW-1:0] edge_value_o
);
  import cep_pkg::*;

  logic [ColW-1:0]    gcol_q;
  logic [ColW-1:0]    gcol;
  logic [ColW-1:0]    raddr;
  logic               enter;
  logic [2*GradW-1:0] rdata;
  grad_t              gw_q [WinN][WinN];
  meta_t              m4_q;
  grad_t              ctr;
  logic [MagW-1:0]    n1, n2, kept;

  // Restart at column zero when the width shrank below the stored column.
  assign gcol  = (FwW'(gcol_q) >= effw_i) ? '0 : gcol_q;
  assign enter = adv_i && meta_i.valid;
  assign raddr = enter ? col_step(gcol, effw_i) : gcol;

  cep_ram #(.Width(2*GradW), .Depth(MaxWidth)) u_line (
    .clk_i   (clk_i),
    .we_i    (enter),
    .waddr_i (gcol),
    .wdata_i ({rdata[GradW-1:0], grad_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcol_q <= '0;
      m4_q   <= '0;
    end else begin
      if (enter) begin
        gcol_q <= col_step(gcol, effw_i);
      end
      if (adv_i) begin
        m4_q <= meta_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enter) begin
      for (int r = 0; r < WinN; r++) begin
        gw_q[r][0] <= gw_q[r][1];
        gw_q[r][1] <= gw_q[r][2];
      end
      gw_q[0][2] <= grad_t'(rdata[2*GradW-1:GradW]);
      gw_q[1][2] <= grad_t'(rdata[GradW-1:0]);
      gw_q[2][2] <= grad_i;
    end
  end

  // Neighbors along the gradient, taken before suppression.
  always_comb begin
    ctr = gw_q[1][1];
    unique case (ctr.sector)
      SectHoriz: begin n1 = gw_q[1][2].mag; n2 = gw_q[1][0].mag; end
      SectDiag:  begin n1 = gw_q[0][2].mag; n2 = gw_q[2][0].mag; end
      SectVert:  begin n1 = gw_q[0][1].mag; n2 = gw_q[2][1].mag; end
      SectAnti:  begin n1 = gw_q[0][0].mag; n2 = gw_q[2][2].mag; end
      default:   begin n1 = '0; n2 = '0; end
    endcase
    kept = (ctr.mag > n1 && ctr.mag > n2) ? ctr.mag : '0;
    priority if (kept >= hi2_i) begin
      edge_value_o = EdgeStrong;
    end else if (kept >= lo2_i) begin
      edge_value_o = EdgeWeak;
    end else begin
      edge_value_o = EdgeNone;
    end
  end

  assign meta_o = m4_q;
endmodule

// ----- hdl/canny_edge_pixel_stream_core.sv -----
// Streaming Canny edge core: takes one raster pixel word per clock and returns
// one edge word per clock once primed, both with no gaps while the sink is ready; the
// result for a pixel comes out 2*W+2 input words after that pixel (W = clamped
// frame width), behind the registered pipeline. Flush words at a frame boundary
// drain the last 2*W+2 pixels. Two line memories (pixel rows and gradient rows),
// each read one column ahead, set the pace; no clearing pass is needed after reset.
module canny_edge_pixel_stream_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cep_pix_if.sink                      pix_i,
  cep_edge_if.source                   edge_o,
  input  logic                         cfg_we_i,
  input  logic [cep_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cep_pkg::CfgDataW-1:0] cfg_data_i
);
  import cep_pkg::*;

  logic [FwW-1:0]   fw_q, effw_q, effw_d;
  logic [FhW-1:0]   fh_q, effh_q, effh_d;
  logic [ThrW-1:0]  lo_q, hi_q;
  logic [MagW-1:0]  lo2_q, hi2_q;
  logic [PrimeW-1:0] lag_q, prime_q;
  logic [ColW-1:0]  in_col_q, ec_q;
  logic [RowW-1:0]  in_row_q, er_q;

  logic adv, acc, is_pix, at_start, flush_ok, push, emit;
  logic ec_wrap, er_last, ic_wrap, ir_last, qint;
  logic [PixW-1:0] pix;
  meta_t m0, m3, m4;
  grad_t g3;
  logic [EdgeW-1:0] ev;

  logic             out_valid_q;
  logic [EdgeW-1:0] out_edge_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic             out_fend_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FwW'(640);
      fh_q <= FhW'(480);
      lo_q <= ThrW'(25);
      hi_q <= ThrW'(75);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFrameWidth:  fw_q <= cfg_data_i[FwW-1:0];
        CfgFrameHeight: fh_q <= cfg_data_i[FhW-1:0];
        CfgLowThr:      lo_q <= cfg_data_i[ThrW-1:0];
        CfgHighThr:     hi_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    effw_d = (fw_q < FwW'(MinDim)) ? FwW'(MinDim)
           : (fw_q > FwW'(MaxWidth)) ? FwW'(MaxWidth) : fw_q;
    effh_d = (fh_q < FhW'(MinDim)) ? FhW'(MinDim)
           : (fh_q > FhW'(MaxHeight)) ? FhW'(MaxHeight) : fh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effw_q <= FwW'(640);
      effh_q <= FhW'(480);
      lag_q  <= PrimeW'(1282);
    end else begin
      effw_q <= effw_d;
      effh_q <= effh_d;
      lag_q  <= PrimeW'({effw_q, 1'b0}) + PrimeW'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    lo2_q <= MagW'(lo_q) * MagW'(lo_q);
    hi2_q <= MagW'(hi_q) * MagW'(hi_q);
  end

  // Accept side
  assign adv         = !out_valid_q || edge_o.ready;
  assign pix_i.ready = adv;

  always_comb begin
    acc      = pix_i.valid && adv;
    is_pix   = (pix_i.kind == KindPixel);
    at_start = (in_col_q == '0) && (in_row_q == '0);
    flush_ok = !is_pix && at_start && (prime_q != '0);
    push     = acc && (is_pix || flush_ok);
    emit     = is_pix ? (prime_q >= lag_q) : 1'b1;
    ec_wrap  = (FwW'(ec_q) + FwW'(1)) >= effw_q;
    er_last  = (FhW'(er_q) + FhW'(1)) >= effh_q;
    ic_wrap  = (FwW'(in_col_q) + FwW'(1)) >= effw_q;
    ir_last  = (FhW'(in_row_q) + FhW'(1)) >= effh_q;
    // Gradient source one row and one column past the described pixel.
    qint     = emit && ((FwW'(ec_q) + FwW'(3)) <= effw_q)
                    && ((FhW'(er_q) + FhW'(3)) <= effh_q);
    pix      = is_pix ? pix_i.pixel_value : '0;
    m0.valid = push;
    m0.emit  = emit;
    m0.qint  = qint;
    m0.fend  = ec_wrap && er_last;
    m0.col   = ec_q;
    m0.row   = er_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      ec_q     <= '0;
      er_q     <= '0;
      prime_q  <= '0;
    end else begin
      if (acc && is_pix) begin
        if (ic_wrap) begin
          in_col_q <= '0;
          in_row_q <= ir_last ? '0 : in_row_q + RowW'(1);
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end
      if (push && emit) begin
        if (ec_wrap) begin
          ec_q <= '0;
          er_q <= er_last ? '0 : er_q + RowW'(1);
        end else begin
          ec_q <= ec_q + ColW'(1);
        end
      end
      if (acc && is_pix && !emit) begin
        prime_q <= prime_q + PrimeW'(1);
      end else if (acc && flush_ok) begin
        prime_q <= prime_q - PrimeW'(1);
      end
    end
  end

  cep_sobel u_sobel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .push_i (push),
    .pix_i  (pix),
    .meta_i (m0),
    .effw_i (effw_q),
    .meta_o (m3),
    .grad_o (g3)
  );

  cep_nms u_nms (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .meta_i       (m3),
    .grad_i       (g3),
    .effw_i       (effw_q),
    .lo2_i        (lo2_q),
    .hi2_i        (hi2_q),
    .meta_o       (m4),
    .edge_value_o (ev)
  );

  // Output register: hold while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m4.valid && m4.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m4.valid && m4.emit) begin
      out_edge_q <= ev;
      out_col_q  <= m4.col;
      out_row_q  <= m4.row;
      out_fend_q <= m4.fend;
    end
  end

  assign edge_o.valid      = out_valid_q;
  assign edge_o.edge_value = out_edge_q;
  assign edge_o.out_col    = out_col_q;
  assign edge_o.out_row    = out_row_q;
  assign edge_o.frame_end  = out_fend_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !edge_o.ready |-> !pix_i.ready)
    else $error("input taken while result word stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && m4.valid && m4.emit |=> out_valid_q)
    else $error("described word lost before output register");

  a_emit_moves_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && emit |=> ec_q != $past(ec_q))
    else $error("emit position did not advance");
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for canny_edge_pixel_stream_core: drives pixel and
// flush words, predicts each edge word and checks it. Needs cep_pkg and the interfaces.
module tb_top;
  import cep_pkg::*;

  localparam int HistDepth = 4 * MaxWidth + 8;

  typedef struct {
    logic [EdgeW-1:0] edge_value;
    logic [ColW-1:0]  out_col;
    logic [RowW-1:0]  out_row;
    logic             frame_end;
  } edge_word_t;

  typedef struct {
    kind_e            kind;
    logic [PixW-1:0]  pixel;
    bit               chk;
    logic [EdgeW-1:0] edge_value;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cep_pix_if  pix ();
  cep_edge_if edg ();

  canny_edge_pixel_stream_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix.sink),
    .edge_o    (edg.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic [PixW-1:0] hist_mem [HistDepth];
  int fw_reg = 640, fh_reg = 480, lo_reg = 25, hi_reg = 75;
  int in_col = 0, in_row = 0, em_col = 0, em_row = 0, pending = 0, wr_pos = 0;

  edge_word_t expected_edges[$];
  int idle_pct = 0, stall_pct = 0, fail_cnt = 0;

  function automatic int eff_w();
    return (fw_reg < MinDim) ? MinDim : (fw_reg > MaxWidth) ? MaxWidth : fw_reg;
  endfunction

  function automatic int eff_h();
    return (fh_reg < MinDim) ? MinDim : (fh_reg > MaxHeight) ? MaxHeight : fh_reg;
  endfunction

  function automatic int px(int pos, int off);
    return int'(hist_mem[(pos + off + 2 * HistDepth) % HistDepth]);
  endfunction

  function automatic int grad_mag2(int pos, int r, int c, int w, int h, output sector_e sect);
    int gx, gy, ax, ay;
    sect = SectHoriz;
    if (r < 1 || r > h - 2 || c < 1 || c > w - 2) return 0;
    gx = -px(pos, -w - 1) - 2 * px(pos, -1) - px(pos, w - 1)
         + px(pos, -w + 1) + 2 * px(pos, 1) + px(pos, w + 1);
    gy = -px(pos, -w - 1) - 2 * px(pos, -w) - px(pos, -w + 1)
         + px(pos, w - 1) + 2 * px(pos, w) + px(pos, w + 1);
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    if (ay == 0 || (ay + ax) * (ay + ax) < 2 * ax * ax) sect = SectHoriz;
    else if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) sect = SectVert;
    else if ((gx > 0) == (gy > 0)) sect = SectDiag;
    else sect = SectAnti;
    return gx * gx + gy * gy;
  endfunction

  function automatic logic [EdgeW-1:0] classify(int pos, int r, int c, int w, int h);
    sector_e sect, unused;
    int m, n1, n2, dr, dc;
    m = grad_mag2(pos, r, c, w, h, sect);
    if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) begin
      case (sect)
        SectHoriz: begin dr = 0;  dc = 1;  end
        SectDiag:  begin dr = -1; dc = 1;  end
        SectVert:  begin dr = -1; dc = 0;  end
        default:   begin dr = -1; dc = -1; end
      endcase
      n1 = grad_mag2((pos + dr * w + dc + 2 * HistDepth) % HistDepth, r + dr, c + dc, w, h,
                     unused);
      n2 = grad_mag2((pos - dr * w - dc + 2 * HistDepth) % HistDepth, r - dr, c - dc, w, h,
                     unused);
      if (!(m > n1 && m > n2)) m = 0;
    end
    if (m >= hi_reg * hi_reg) return EdgeStrong;
    if (m >= lo_reg * lo_reg) return EdgeWeak;
    return EdgeNone;
  endfunction

  function automatic edge_word_t describe_oldest(int depth);
    edge_word_t ew;
    int w, h, pos;
    w = eff_w();
    h = eff_h();
    pos = (wr_pos + HistDepth - (depth % HistDepth)) % HistDepth;
    ew.edge_value = classify(pos, em_row, em_col, w, h);
    ew.out_col = em_col[ColW-1:0];
    ew.out_row = em_row[RowW-1:0];
    ew.frame_end = (em_col + 1 >= w && em_row + 1 >= h);
    em_col++;
    if (em_col >= w) begin
      em_col = 0;
      em_row++;
      if (em_row >= h) em_row = 0;
    end
    return ew;
  endfunction

  // Advance the predictor by one accepted word; returns 1 with the edge word if one is due.
  function automatic bit predict_edge(kind_e k, logic [PixW-1:0] p, output edge_word_t ew);
    int w, h;
    w = eff_w();
    h = eff_h();
    ew = '{default: '0};
    if (k == KindPixel) begin
      hist_mem[wr_pos] = p;
      wr_pos = (wr_pos + 1) % HistDepth;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (pending + 1 > 2 * w + 2) begin
        ew = describe_oldest(pending + 1);
        return 1;
      end
      pending++;
      return 0;
    end
    if (in_col != 0 || in_row != 0 || pending == 0) return 0;
    ew = describe_oldest(pending);
    pending--;
    return 1;
  endfunction

  task automatic send_word(kind_e k, logic [PixW-1:0] p, bit chk, logic [EdgeW-1:0] ev);
    edge_word_t ew;
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.kind        <= k;
    pix.pixel_value <= p;
    do @(posedge clk_i); while (!pix.ready);
    if (predict_edge(k, p, ew)) begin
      if (chk) ew.edge_value = ev;
      expected_edges.push_back(ew);
    end
  endtask

  task automatic drain_wait();
    pix.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFrameWidth:  fw_reg = val & 'h7FF;
      CfgFrameHeight: fh_reg = val & 'h1FFF;
      CfgLowThr:      lo_reg = val & 'h7FF;
      default:        hi_reg = val & 'h7FF;
    endcase
  endtask

  // One full frame plus its drain; returns the number of words that did something.
  task automatic run_frame(int shape, output int used);
    int w, h, split, lo_v, hi_v;
    logic [PixW-1:0] p;
    w = eff_w();
    h = eff_h();
    used = 0;
    split = $urandom_range(w - 1);
    lo_v = $urandom_range(255);
    hi_v = $urandom_range(255);
    for (int i = 0; i < w * h; i++) begin
      case (shape)
        0:       p = PixW'($urandom_range(255));
        1:       p = (in_col >= split) ? PixW'(hi_v) : PixW'(lo_v);
        2:       p = (in_row >= 1 + (in_col % 2)) ? PixW'(hi_v) : PixW'(lo_v);
        default: p = (in_col + in_row >= split) ? PixW'(hi_v) : PixW'(lo_v);
      endcase
      // ignored flush in mid-frame as noise
      if (i > 0 && $urandom_range(19) == 0) begin
        send_word(KindFlush, PixW'($urandom_range(255)), 0, '0);
      end
      send_word(KindPixel, p, 0, '0);
      used++;
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      send_word(KindFlush, PixW'($urandom_range(255)), 0, '0);
      used++;
    end
    if ($urandom_range(3) == 0) send_word(KindFlush, PixW'($urandom_range(255)), 0, '0);
  endtask

  // Output side: random backpressure and in-order compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edg.ready <= 1'b0;
    end else begin
      edg.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    edge_word_t ew;
    if (rst_ni && edg.valid && edg.ready) begin
      if (expected_edges.size() == 0) begin
        $error("edge word with nothing expected: col %0d row %0d", edg.out_col, edg.out_row);
        fail_cnt++;
      end else begin
        ew = expected_edges.pop_front();
        if (edg.edge_value !== ew.edge_value) begin
          $error("edge_value expected %0d actual %0d", ew.edge_value, edg.edge_value);
          fail_cnt++;
        end
        if (edg.out_col !== ew.out_col) begin
          $error("out_col expected %0d actual %0d", ew.out_col, edg.out_col);
          fail_cnt++;
        end
        if (edg.out_row !== ew.out_row) begin
          $error("out_row expected %0d actual %0d", ew.out_row, edg.out_row);
          fail_cnt++;
        end
        if (edg.frame_end !== ew.frame_end) begin
          $error("frame_end expected %0d actual %0d", ew.frame_end, edg.frame_end);
          fail_cnt++;
        end
      end
    end
  end

  stim_row_t dir_rows[20] = '{
    '{KindFlush, 8'd0,   0, 8'd0},   // flush with nothing pending
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindPixel, 8'd255, 0, 8'd0},
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindFlush, 8'd255, 0, 8'd0},   // mid-frame, ignored
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindPixel, 8'd255, 0, 8'd0},
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindPixel, 8'd0,   0, 8'd0},
    '{KindPixel, 8'd255, 1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeStrong},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   1, EdgeNone},
    '{KindFlush, 8'd0,   0, 8'd0}
  };

  initial begin
    int items, used, phase;
    pix.valid = 1'b0;
    pix.kind = KindPixel;
    pix.pixel_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    write_reg(CfgFrameWidth, 3);
    write_reg(CfgFrameHeight, 3);
    foreach (dir_rows[i]) send_word(dir_rows[i].kind, dir_rows[i].pixel, dir_rows[i].chk,
                                    dir_rows[i].edge_value);
    drain_wait();

    items = 0;
    phase = 0;
    while (items < 450) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      write_reg(CfgFrameWidth, ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10));
      write_reg(CfgFrameHeight, ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 6));
      case ($urandom_range(4))
        0: write_reg(CfgLowThr, 0);
        1: write_reg(CfgLowThr, 2047);
        default: write_reg(CfgLowThr, $urandom_range(400));
      endcase
      case ($urandom_range(4))
        0: write_reg(CfgHighThr, 0);
        1: write_reg(CfgHighThr, 2047);
        default: write_reg(CfgHighThr, $urandom_range(200, 1100));
      endcase
      run_frame($urandom_range(3), used);
      items += used;
      phase++;
      drain_wait();
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
